// ===== rtl/u8u16_pkg.sv =====
// constants and types shared by the utf-8 to utf-16 decoder
`default_nettype none

package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] HIGH_BASE    = 16'hD800;
    localparam logic [15:0] LOW_BASE     = 16'hDC00;
    localparam logic [15:0] PLANE_OFFSET = 16'h0040;
    localparam logic [15:0] PLANE_LIMIT  = 16'h0400;
    localparam logic [7:0]  CONT_BITS    = 8'h3F;

    // lowest and one past highest value of the first two bytes of a 4-byte form
    localparam logic [20:0] PLANE_LOW  = 21'(PLANE_OFFSET >> 2);
    localparam logic [20:0] PLANE_HIGH = 21'((PLANE_OFFSET + PLANE_LIMIT) >> 2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one result word
    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_string;
        logic [1:0]  leftover_bytes;
        logic        status;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/utf8_to_utf16_decoder_unit.sv =====
// utf-8 to utf-16 stream decoder, top level
//
// usage:
//   input channel s_axis_*: one utf-8 byte per word, tlast marks the byte that
//   ends the string. output channel m_axis_*: one utf-16 code unit per word.
//   a 4-byte sequence gives two words (high then low surrogate). malformed
//   input gives 0xFFFD. at end of string the final word carries tlast; if the
//   string ended inside a sequence that word has has_unit 0 and reports the
//   bytes left over, with status 1 when nothing was decoded in the string.
//   results: the words of a byte are written to the queue as it is accepted, and the queue head drives m_axis_*.
//   throughput: one byte per cycle; the decode logic sits between the state
//   registers and a 4-word result queue, so a new byte is taken each cycle
//   while the queue holds at most two words.
//   stall: when m_axis_tready is low the queue fills and s_axis_tready drops
//   once three or more words wait; s_axis_tready does not depend on
//   m_axis_tready combinationally.
//   reset: aresetn low (synchronous) empties the queue and clears the decode
//   state; the next byte starts a new string.
`default_nettype none

module utf8_to_utf16_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input word
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // result word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] code_unit, [17:16] leftover_bytes,
                                             // [18] status, [23:19] zero
    output logic [0:0]       m_axis_tuser,   // [0] has_unit
    output logic             m_axis_tlast    // end_of_string
);
    import u8u16_pkg::*;

    // decode state
    logic [20:0] accum_reg, accum_next;
    logic [1:0]  need_reg, need_next;
    logic [1:0]  held_reg, held_next;
    logic        any_reg, any_next;

    // result queue
    res_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    logic        in_fire;
    logic        out_fire;
    logic [1:0]  num_units;
    logic [1:0]  push_n;
    logic [15:0] unit0, unit1;
    res_t        res0, res1;
    logic [2:0]  seq_len;
    logic [20:0] acc_shift;
    logic [10:0] hi_full;
    logic [1:0]  left;
    logic [QPTR_W-1:0] wr_ptr_plus1;

    // ready while at least two queue slots stay free
    assign s_axis_tready = (count_reg <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_plus1  = wr_ptr_reg + QPTR_W'(1);

    // byte decode
    always_comb begin
        accum_next = accum_reg;
        need_next  = need_reg;
        held_next  = held_reg;
        any_next   = any_reg;
        num_units  = 2'd0;
        unit0      = '0;
        unit1      = '0;
        seq_len    = 3'(held_reg) + 3'(need_reg);
        acc_shift  = {accum_reg[14:0], s_axis_tdata[5:0] & CONT_BITS[5:0]};
        hi_full    = acc_shift[20:10] - PLANE_OFFSET[10:0];
        left       = 2'd0;
        res0       = '0;
        res1       = '0;

        if (need_reg == 2'd0) begin
            if (s_axis_tdata[7] == 1'b0) begin
                // plain ascii
                num_units = 2'd1;
                unit0     = {8'h00, s_axis_tdata};
            end else if (s_axis_tdata[7:5] == 3'b110) begin
                accum_next = {16'h0, s_axis_tdata[4:0]};
                need_next  = 2'd1;
                held_next  = 2'd1;
            end else if (s_axis_tdata[7:4] == 4'b1110) begin
                accum_next = {17'h0, s_axis_tdata[3:0]};
                need_next  = 2'd2;
                held_next  = 2'd1;
            end else if (s_axis_tdata[7:3] == 5'b11110) begin
                accum_next = {18'h0, s_axis_tdata[2:0]};
                need_next  = 2'd3;
                held_next  = 2'd1;
            end else begin
                // stray continuation or bad lead
                num_units = 2'd1;
                unit0     = REPL_UNIT;
            end
        end else if (s_axis_tdata[7:6] != 2'b10) begin
            // missing continuation, this byte is swallowed
            num_units  = 2'd1;
            unit0      = REPL_UNIT;
            accum_next = '0;
            need_next  = 2'd0;
            held_next  = 2'd0;
        end else begin
            accum_next = acc_shift;
            held_next  = held_reg + 2'd1;
            need_next  = need_reg - 2'd1;
            if (seq_len == 3'd4 && need_next == 2'd2 &&
                (acc_shift < PLANE_LOW || acc_shift >= PLANE_HIGH)) begin
                // 4-byte value outside the supplementary planes
                num_units  = 2'd1;
                unit0      = REPL_UNIT;
                accum_next = '0;
                need_next  = 2'd0;
                held_next  = 2'd0;
            end else if (need_next == 2'd0) begin
                if (seq_len == 3'd4) begin
                    num_units = 2'd2;
                    unit0     = HIGH_BASE | {6'h00, hi_full[9:0]};
                    unit1     = LOW_BASE  | {6'h00, acc_shift[9:0]};
                end else begin
                    num_units = 2'd1;
                    unit0     = acc_shift[15:0];
                end
                accum_next = '0;
                need_next  = 2'd0;
                held_next  = 2'd0;
            end
        end

        if (num_units != 2'd0) begin
            any_next = 1'b1;
        end

        res0.code_unit = unit0;
        res0.has_unit  = 1'b1;
        res1.code_unit = unit1;
        res1.has_unit  = 1'b1;
        push_n         = num_units;

        if (s_axis_tlast) begin
            if (num_units == 2'd2) begin
                res1.end_of_string = 1'b1;
            end else if (num_units == 2'd1) begin
                res0.end_of_string = 1'b1;
            end else begin
                // cut-off tail or nothing open: one closing word
                left                = (need_next != 2'd0) ? held_next : 2'd0;
                res0.code_unit      = '0;
                res0.has_unit       = 1'b0;
                res0.end_of_string  = 1'b1;
                res0.leftover_bytes = left;
                res0.status         = (left != 2'd0) && !any_reg;
                push_n              = 2'd1;
            end
            accum_next = '0;
            need_next  = 2'd0;
            held_next  = 2'd0;
            any_next   = 1'b0;
        end

        if (!in_fire) begin
            accum_next = accum_reg;
            need_next  = need_reg;
            held_next  = held_reg;
            any_next   = any_reg;
            push_n     = 2'd0;
        end
    end

    // queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(out_fire);
        count_next  = count_reg + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg  <= '0;
            need_reg   <= '0;
            held_reg   <= '0;
            any_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            accum_reg  <= accum_next;
            need_reg   <= need_next;
            held_reg   <= held_next;
            any_reg    <= any_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_plus1] <= res1;
        end
    end

    // head of queue drives the result word
    assign m_axis_tdata = {5'b0,
                           queue_reg[rd_ptr_reg].status,
                           queue_reg[rd_ptr_reg].leftover_bytes,
                           queue_reg[rd_ptr_reg].code_unit};
    assign m_axis_tuser = queue_reg[rd_ptr_reg].has_unit;
    assign m_axis_tlast = queue_reg[rd_ptr_reg].end_of_string;

endmodule

`default_nettype wire

// ===== dv/tb_utf8_to_utf16_decoder_unit.sv =====
// self-checking testbench for the utf-8 to utf-16 stream decoder
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder_unit;

    import u8u16_pkg::*;

    // clock, reset and the decoder inputs, all known from time zero
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [15:0] code_unit, [17:16] leftover_bytes, [18] status
    logic [0:0]  m_axis_tuser;            // [0] has_unit
    logic        m_axis_tlast;            // end_of_string

    utf8_to_utf16_decoder_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 aclk = ~aclk;

    // decoder state mirrored by the predictor
    logic [20:0] dec_acc     = '0;
    logic [1:0]  dec_need    = '0;
    logic [1:0]  dec_held    = '0;
    logic        dec_emitted = 1'b0;

    res_t unit_q[$];          // predicted result words, oldest first

    int  errors        = 0;
    int  bytes_sent    = 0;
    int  strings_sent  = 0;
    int  units_checked = 0;
    bit  calm          = 1'b0; // no idling on either side when set
    int  hold_req      = 0;    // cycles the sink is asked to hold off

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic clear_seq();
        dec_acc  = '0;
        dec_need = '0;
        dec_held = '0;
    endtask

    // work out the result words of one accepted byte and queue them
    task automatic predict_utf16(input logic [7:0] in_b, input logic is_last);
        logic [15:0] cu [2];
        logic [20:0] hi;
        int          n;
        int          seq_len;
        res_t        r;
        n = 0;
        if (dec_need == 2'd0) begin
            if (in_b < 8'h80) begin
                cu[n] = {8'h00, in_b};
                n++;
            end else if (in_b[7:5] == 3'b110) begin
                dec_acc  = {16'd0, in_b[4:0]};
                dec_need = 2'd1;
                dec_held = 2'd1;
            end else if (in_b[7:4] == 4'b1110) begin
                dec_acc  = {17'd0, in_b[3:0]};
                dec_need = 2'd2;
                dec_held = 2'd1;
            end else if (in_b[7:3] == 5'b11110) begin
                dec_acc  = {18'd0, in_b[2:0]};
                dec_need = 2'd3;
                dec_held = 2'd1;
            end else begin
                // bad lead byte or stray continuation
                cu[n] = REPL_UNIT;
                n++;
            end
        end else if (in_b[7:6] != 2'b10) begin
            // missing continuation, the byte itself is swallowed
            cu[n] = REPL_UNIT;
            n++;
            clear_seq();
        end else begin
            seq_len  = int'(dec_held) + int'(dec_need);
            dec_acc  = {dec_acc[14:0], in_b[5:0]};
            dec_held = dec_held + 2'd1;
            dec_need = dec_need - 2'd1;
            if (seq_len == 4 && dec_need == 2'd2 &&
                (dec_acc < PLANE_LOW || dec_acc >= PLANE_HIGH)) begin
                // 4-byte form outside the supplementary planes
                cu[n] = REPL_UNIT;
                n++;
                clear_seq();
            end else if (dec_need == 2'd0) begin
                if (seq_len == 4) begin
                    hi    = (dec_acc >> 10) - 21'(PLANE_OFFSET);
                    cu[0] = HIGH_BASE | {6'd0, hi[9:0]};
                    cu[1] = LOW_BASE | {6'd0, dec_acc[9:0]};
                    n     = 2;
                end else begin
                    cu[n] = dec_acc[15:0];
                    n++;
                end
                clear_seq();
            end
        end
        if (n > 0)
            dec_emitted = 1'b1;
        for (int i = 0; i < n; i++) begin
            r.code_unit      = cu[i];
            r.has_unit       = 1'b1;
            r.end_of_string  = is_last && (i == n - 1);
            r.leftover_bytes = 2'd0;
            r.status         = 1'b0;
            unit_q.push_back(r);
        end
        if (is_last) begin
            if (n == 0) begin
                // string ended inside a sequence
                r.code_unit      = 16'h0000;
                r.has_unit       = 1'b0;
                r.end_of_string  = 1'b1;
                r.leftover_bytes = (dec_need != 2'd0) ? dec_held : 2'd0;
                r.status         = (r.leftover_bytes != 2'd0) && !dec_emitted;
                unit_q.push_back(r);
            end
            clear_seq();
            dec_emitted = 1'b0;
        end
    endtask

    // offer one byte until taken, then maybe leave a gap
    task automatic send_byte(input logic [7:0] in_b, input logic is_last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= in_b;
        s_axis_tlast  <= is_last;
        do @(posedge aclk); while (!s_axis_tready);
        predict_utf16(in_b, is_last);
        bytes_sent++;
        if (is_last)
            strings_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_seq(input logic [7:0] bq[$]);
        foreach (bq[i])
            send_byte(bq[i], i == bq.size() - 1);
    endtask

    // sender stops until every predicted word has been seen
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (unit_q.size() != 0);
    endtask

    // first keep bytes of the utf-8 form of cp with the given length
    task automatic encode_char(input logic [20:0] cp, input int len, input int keep,
                               inout logic [7:0] bq[$]);
        logic [7:0] enc [4];
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            bq.push_back(enc[i]);
    endtask

    task automatic pick_char(output logic [20:0] cp, output int len);
        len = $urandom_range(1, 4);
        case (len)
            1: cp = 21'($urandom_range(0, 8'h7F));
            2: cp = 21'($urandom_range(0, 16'h07FF));
            3: cp = 21'($urandom_range(0, 16'hFFFF));
            // mostly in range, now and then any 21-bit value
            default: cp = ($urandom_range(0, 7) == 0) ? 21'($urandom) :
                          21'($urandom_range(32'h10000, 32'h10FFFF));
        endcase
    endtask

    // mostly well-formed text with some noise, broken and cut-off sequences
    task automatic send_random_string(input int max_chars);
        logic [7:0]  bq[$];
        logic [20:0] cp;
        int          len;
        repeat ($urandom_range(1, max_chars)) begin
            pick_char(cp, len);
            case ($urandom_range(0, 19))
                0, 1: begin
                    // one random byte in place of the character
                    bq.push_back(8'($urandom));
                    len = 1;
                end
                default: encode_char(cp, len, len, bq);
            endcase
            // drop the tail of a multi-byte form now and then
            if (len > 1 && $urandom_range(0, 19) == 0)
                repeat ($urandom_range(1, len - 1)) void'(bq.pop_back());
        end
        if ($urandom_range(0, 5) == 0) begin
            pick_char(cp, len);
            if (len == 1)
                len = 4;
            encode_char(cp, len, $urandom_range(1, len - 1), bq);
        end
        send_seq(bq);
    endtask

    task automatic test_valid_forms();
        send_seq('{8'h00, 8'h7F});
        send_seq('{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                   8'hE0, 8'h80, 8'h80});   // last one is overlong, passed through
    endtask

    task automatic test_malformed();
        // bad lead, stray continuation, missing continuation swallowing 'A'
        send_seq('{8'hFF, 8'h80, 8'hC3, 8'h41});
        // above the top plane: replaced at the second byte, the rest are stray
        send_seq('{8'hF4, 8'h90, 8'h80});
    endtask

    task automatic test_string_ends();
        send_seq('{8'hE2, 8'h82});                  // cut off, nothing decoded
        send_seq('{8'h41, 8'hF0, 8'h9F, 8'h98});    // cut off after a unit
    endtask

    task automatic test_random_strings(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            send_random_string(8);
            if (!calm && strings_sent % 12 == 0)
                drain_pause();
        end
    endtask

    // sink holds off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        logic [7:0]  bq[$];
        logic [20:0] cp;
        int          len;
        drain_pause();
        hold_req = 200;
        repeat (12) begin
            pick_char(cp, len);
            encode_char(cp, len, len, bq);
        end
        send_seq(bq);
    endtask

    task automatic test_steady(input int target);
        calm = 1'b1;
        test_random_strings(target);
    endtask

    // result sink: random stalls, a long hold when asked, none when calm
    initial begin : sink
        int n;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_req != 0) begin
                n = hold_req;
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (unit_q.size() == 0) begin
                note_mismatch($sformatf("unexpected word tdata=%h", m_axis_tdata));
            end else begin
                want = unit_q.pop_front();
                units_checked++;
                if (m_axis_tdata[15:0] != want.code_unit)
                    note_mismatch($sformatf("code_unit %h, want %h",
                                            m_axis_tdata[15:0], want.code_unit));
                if (m_axis_tuser[0] != want.has_unit)
                    note_mismatch($sformatf("has_unit %b, want %b",
                                            m_axis_tuser[0], want.has_unit));
                if (m_axis_tlast != want.end_of_string)
                    note_mismatch($sformatf("end_of_string %b, want %b",
                                            m_axis_tlast, want.end_of_string));
                if (m_axis_tdata[17:16] != want.leftover_bytes)
                    note_mismatch($sformatf("leftover_bytes %0d, want %0d",
                                            m_axis_tdata[17:16], want.leftover_bytes));
                if (m_axis_tdata[18] != want.status)
                    note_mismatch($sformatf("status %b, want %b",
                                            m_axis_tdata[18], want.status));
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_valid_forms();
        test_malformed();
        test_string_ends();
        test_random_strings(400);
        test_backpressure();
        test_random_strings(100);
        test_steady(200);

        s_axis_tvalid <= 1'b0;
        while (unit_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("decoded %0d bytes in %0d strings, %0d result words checked",
                 bytes_sent, strings_sent, units_checked);
        $display("valid, malformed and cut-off forms under random and long stalls");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // give up long after the slowest correct run would have ended
    initial begin
        #3600000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== utf8_to_utf16_decoder_unit.f =====
rtl/u8u16_pkg.sv
rtl/utf8_to_utf16_decoder_unit.sv
dv/tb_utf8_to_utf16_decoder_unit.sv
